### rtl/core/sre_pkg.sv
// ----------------------------------------------------------------------------
// sre_pkg
// Shared types and constants for the streaming rotary embedding unit.
// ----------------------------------------------------------------------------
package sre_pkg;

  // fixed payload widths
  localparam int unsigned DataW        = 16;
  localparam int unsigned CoefW        = 16;
  localparam int unsigned CoefFracBits = 14;
  localparam int unsigned PairW        = 6;

  // configuration register widths and limits
  localparam int unsigned HalfW        = 7;
  localparam int unsigned HeadW        = 7;
  localparam int unsigned PosW         = 13;
  localparam int unsigned HeadCntW     = 6;
  localparam int unsigned PosCntW      = 12;
  localparam int unsigned MaxHeads     = 64;
  localparam int unsigned MaxPositions = 4096;

  // register port
  localparam int unsigned RegAddrW     = 4;
  localparam int unsigned RegDataW     = 32;

  localparam logic [HalfW-1:0] HalfWidthRst     = 7'd64;
  localparam logic [HeadW-1:0] HeadCountRst     = 7'd1;
  localparam logic [PosW-1:0]  PositionCountRst = 13'd1;

  typedef enum logic [1:0] {
    REG_HALF_WIDTH     = 2'd0,
    REG_HEAD_COUNT     = 2'd1,
    REG_POSITION_COUNT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] element_value;
    logic signed [CoefW-1:0] cos_value;
    logic signed [CoefW-1:0] sin_value;
  } in_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] rotated_first;
    logic signed [DataW-1:0] rotated_second;
    logic [PairW-1:0]        pair_index;
    logic                    saturated;
    logic                    last_of_run;
  } out_req_t;

  // one buffered first-half element with its coefficients
  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [CoefW-1:0] c;
    logic signed [CoefW-1:0] s;
  } entry_t;

  // sequencer verdict for the element being accepted
  typedef struct packed {
    logic             second;
    logic             last_of_run;
    logic [PairW-1:0] pair_index;
  } slot_t;

endpackage

### rtl/core/sre_ram.sv
// ----------------------------------------------------------------------------
// sre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sre_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sre_seq.sv
// ----------------------------------------------------------------------------
// sre_seq
// Element, head and position counters; picks the store address per element.
// ----------------------------------------------------------------------------
module sre_seq #(
  parameter int MaxHalf = 64
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      accept_i,
  input  logic [sre_pkg::HalfW-1:0]                 half_width_i,
  input  logic [sre_pkg::HeadW-1:0]                 head_count_i,
  input  logic [sre_pkg::PosW-1:0]                  position_count_i,
  output sre_pkg::slot_t                            slot_o,
  output logic [(MaxHalf > 1 ? $clog2(MaxHalf) : 1)-1:0] addr_o
);

  localparam int AddrW = (MaxHalf > 1) ? $clog2(MaxHalf) : 1;
  localparam int CntW  = ($clog2(2 * MaxHalf + 1) > 8) ? $clog2(2 * MaxHalf + 1) : 8;

  logic [CntW-1:0]             elem_q, elem_d;
  logic [sre_pkg::HeadCntW-1:0] head_q, head_d;
  logic [sre_pkg::PosCntW-1:0]  pos_q, pos_d;

  logic [CntW-1:0]             eff_h, two_h, cnt_eff, cnt_inc, pair_j, h_m1;
  logic [sre_pkg::HeadW-1:0]   heads_eff, heads_m1_full, head_inc;
  logic [sre_pkg::PosW-1:0]    poss_eff, poss_m1_full, pos_inc;
  logic                        second;

  always_comb begin
    if (half_width_i == '0) begin
      eff_h = CntW'(1);
    end else if (CntW'(half_width_i) > CntW'(MaxHalf)) begin
      eff_h = CntW'(MaxHalf);
    end else begin
      eff_h = CntW'(half_width_i);
    end

    if (head_count_i == '0) begin
      heads_eff = sre_pkg::HeadW'(1);
    end else if (head_count_i > sre_pkg::HeadW'(sre_pkg::MaxHeads)) begin
      heads_eff = sre_pkg::HeadW'(sre_pkg::MaxHeads);
    end else begin
      heads_eff = head_count_i;
    end

    if (position_count_i == '0) begin
      poss_eff = sre_pkg::PosW'(1);
    end else if (position_count_i > sre_pkg::PosW'(sre_pkg::MaxPositions)) begin
      poss_eff = sre_pkg::PosW'(sre_pkg::MaxPositions);
    end else begin
      poss_eff = position_count_i;
    end
  end

  assign two_h         = {eff_h[CntW-2:0], 1'b0};
  assign h_m1          = eff_h - CntW'(1);
  assign heads_m1_full = heads_eff - sre_pkg::HeadW'(1);
  assign poss_m1_full  = poss_eff - sre_pkg::PosW'(1);

  // a counter left past the end by a config change restarts the vector
  assign cnt_eff = (elem_q >= two_h) ? '0 : elem_q;
  assign second  = (cnt_eff >= eff_h);
  assign pair_j  = cnt_eff - eff_h;
  assign cnt_inc = cnt_eff + CntW'(1);
  assign head_inc = {1'b0, head_q} + sre_pkg::HeadW'(1);
  assign pos_inc  = {1'b0, pos_q} + sre_pkg::PosW'(1);

  assign addr_o = second ? pair_j[AddrW-1:0] : cnt_eff[AddrW-1:0];

  assign slot_o.second      = second;
  assign slot_o.pair_index  = pair_j[sre_pkg::PairW-1:0];
  assign slot_o.last_of_run = second && (pair_j == h_m1)
                            && (head_q == heads_m1_full[sre_pkg::HeadCntW-1:0])
                            && (pos_q == poss_m1_full[sre_pkg::PosCntW-1:0]);

  always_comb begin
    elem_d = elem_q;
    head_d = head_q;
    pos_d  = pos_q;
    if (accept_i) begin
      elem_d = cnt_inc;
      if (second && (cnt_inc >= two_h)) begin
        elem_d = '0;
        if (head_inc >= heads_eff) begin
          head_d = '0;
          pos_d  = (pos_inc >= poss_eff) ? '0 : pos_inc[sre_pkg::PosCntW-1:0];
        end else begin
          head_d = head_inc[sre_pkg::HeadCntW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= '0;
      head_q <= '0;
      pos_q  <= '0;
    end else begin
      elem_q <= elem_d;
      head_q <= head_d;
      pos_q  <= pos_d;
    end
  end

endmodule

### rtl/core/sre_rot.sv
// ----------------------------------------------------------------------------
// sre_rot
// Rotation pipeline: products, round/shift/saturate, output register.
// ----------------------------------------------------------------------------
module sre_rot (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  sre_pkg::slot_t                 slot_i,
  input  logic signed [sre_pkg::DataW-1:0] x2_i,
  input  sre_pkg::entry_t                entry_i,
  output logic                           ready_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sre_pkg::out_req_t              out_data_o
);

  localparam int ProdW = sre_pkg::DataW + sre_pkg::CoefW;
  localparam int SumW  = ProdW + 1;
  localparam int ShW   = SumW - sre_pkg::CoefFracBits;
  localparam int DW    = sre_pkg::DataW;

  localparam logic signed [SumW-1:0] RoundBias = SumW'(1) << (sre_pkg::CoefFracBits - 1);
  localparam logic signed [ShW-1:0]  SatHi = {{(ShW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [ShW-1:0]  SatLo = {{(ShW - DW + 1){1'b1}}, {(DW - 1){1'b0}}};

  // returns {clip, value}
  function automatic logic [DW:0] scale_sat(input logic signed [SumW-1:0] acc);
    logic signed [SumW-1:0] rnd;
    logic signed [SumW-1:0] shifted;
    logic signed [ShW-1:0]  q;
    rnd     = acc + RoundBias;
    shifted = rnd >>> sre_pkg::CoefFracBits;
    q       = shifted[ShW-1:0];
    if (q > SatHi) begin
      return {1'b1, SatHi[DW-1:0]};
    end else if (q < SatLo) begin
      return {1'b1, SatLo[DW-1:0]};
    end
    return {1'b0, q[DW-1:0]};
  endfunction

  logic ready_s1, ready_s2, ready_out;

  // stage 1: slot and second-half element; RAM data lines up with it
  logic                       s1_v_q;
  sre_pkg::slot_t             s1_slot_q;
  logic signed [DW-1:0]       s1_x2_q;

  // stage 2: partial products
  logic                       s2_v_q;
  sre_pkg::slot_t             s2_slot_q;
  logic signed [ProdW-1:0]    p_x1c_q, p_x2s_q, p_x2c_q, p_x1s_q;

  logic                       out_v_q;
  sre_pkg::out_req_t          out_q, out_d;

  logic signed [SumW-1:0]     sum_first, sum_second;
  logic [DW:0]                res_first, res_second;

  assign ready_out = !out_v_q || !out_stall_i;
  assign ready_s2  = !s2_v_q || ready_out;
  assign ready_s1  = !s1_v_q || ready_s2;
  assign ready_o   = ready_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (ready_s1) begin
        s1_v_q <= load_i;
      end
      if (ready_s2) begin
        s2_v_q <= s1_v_q;
      end
      if (ready_out) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_s1 && load_i) begin
      s1_slot_q <= slot_i;
      s1_x2_q   <= x2_i;
    end
    if (ready_s2 && s1_v_q) begin
      s2_slot_q <= s1_slot_q;
      p_x1c_q   <= ProdW'(entry_i.x * entry_i.c);
      p_x2s_q   <= ProdW'(s1_x2_q * entry_i.s);
      p_x2c_q   <= ProdW'(s1_x2_q * entry_i.c);
      p_x1s_q   <= ProdW'(entry_i.x * entry_i.s);
    end
    if (ready_out && s2_v_q) begin
      out_q <= out_d;
    end
  end

  assign sum_first  = {p_x1c_q[ProdW-1], p_x1c_q} - {p_x2s_q[ProdW-1], p_x2s_q};
  assign sum_second = {p_x2c_q[ProdW-1], p_x2c_q} + {p_x1s_q[ProdW-1], p_x1s_q};
  assign res_first  = scale_sat(sum_first);
  assign res_second = scale_sat(sum_second);

  always_comb begin
    out_d.rotated_first  = res_first[DW-1:0];
    out_d.rotated_second = res_second[DW-1:0];
    out_d.pair_index     = s2_slot_q.pair_index;
    out_d.saturated      = res_first[DW] | res_second[DW];
    out_d.last_of_run    = s2_slot_q.last_of_run;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/streaming_rotary_embedding_unit.sv
// ----------------------------------------------------------------------------
// streaming_rotary_embedding_unit
// Rotary position embedding over a row-major stream of head-vector elements.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one element plus its cos/sin (Q2.14); order is
//   position, head, dim. The first half_width elements of a head vector are
//   written to the pair store; each second-half element reads its partner
//   and yields one output request with both rotated values.
//   After a second-half element is accepted, its request passes stage 1,
//   stage 2 and the output register; first-half elements produce no output.
//   Throughput is one element per cycle unless stalled: each element uses
//   the store's single write or single read port once, and the three
//   pipeline stages (store read, multiply, round/saturate) each hold one pair.
//   When the receiver stalls, the pipeline fills up behind the output
//   register; input stall rises only once every stage holds a pair.
//   Reset clears the counters and pipeline valids and loads half_width 64,
//   head_count 1, position_count 1. Store contents are not cleared; at a
//   fixed half_width a first-half element writes before its pair is read.
//   Write registers via the APB port only while the stream idles; unenforced.
// ----------------------------------------------------------------------------
module streaming_rotary_embedding_unit #(
  parameter int MaxHalf = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  sre_pkg::in_req_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sre_pkg::out_req_t                 out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sre_pkg::RegAddrW-1:0]      paddr,
  input  logic [sre_pkg::RegDataW-1:0]      pwdata,
  output logic [sre_pkg::RegDataW-1:0]      prdata,
  output logic                              pready
);

  localparam int AddrW = (MaxHalf > 1) ? $clog2(MaxHalf) : 1;

  logic [sre_pkg::HalfW-1:0] half_width_q;
  logic [sre_pkg::HeadW-1:0] head_count_q;
  logic [sre_pkg::PosW-1:0]  position_count_q;

  sre_pkg::reg_idx_e         reg_idx;
  logic                      reg_wr;

  logic                      accept;
  logic                      rot_ready;
  sre_pkg::slot_t            slot;
  logic [AddrW-1:0]          store_addr;
  sre_pkg::entry_t           wr_entry;
  logic [$bits(sre_pkg::entry_t)-1:0] rd_bits;

  // ---- register port ----
  assign pready  = 1'b1;
  assign reg_idx = sre_pkg::reg_idx_e'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q     <= sre_pkg::HalfWidthRst;
      head_count_q     <= sre_pkg::HeadCountRst;
      position_count_q <= sre_pkg::PositionCountRst;
    end else if (reg_wr) begin
      case (reg_idx)
        sre_pkg::REG_HALF_WIDTH:     half_width_q     <= pwdata[sre_pkg::HalfW-1:0];
        sre_pkg::REG_HEAD_COUNT:     head_count_q     <= pwdata[sre_pkg::HeadW-1:0];
        sre_pkg::REG_POSITION_COUNT: position_count_q <= pwdata[sre_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sre_pkg::REG_HALF_WIDTH:     prdata = sre_pkg::RegDataW'(half_width_q);
      sre_pkg::REG_HEAD_COUNT:     prdata = sre_pkg::RegDataW'(head_count_q);
      sre_pkg::REG_POSITION_COUNT: prdata = sre_pkg::RegDataW'(position_count_q);
      default:                     prdata = '0;
    endcase
  end

  // ---- stream ----
  assign in_stall_o = !rot_ready;
  assign accept     = in_valid_i && rot_ready;

  sre_seq #(
    .MaxHalf (MaxHalf)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .half_width_i     (half_width_q),
    .head_count_i     (head_count_q),
    .position_count_i (position_count_q),
    .slot_o           (slot),
    .addr_o           (store_addr)
  );

  assign wr_entry.x = in_data_i.element_value;
  assign wr_entry.c = in_data_i.cos_value;
  assign wr_entry.s = in_data_i.sin_value;

  sre_ram #(
    .Width ($bits(sre_pkg::entry_t)),
    .Depth (MaxHalf)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && !slot.second),
    .waddr_i (store_addr),
    .wdata_i (wr_entry),
    .re_i    (accept && slot.second),
    .raddr_i (store_addr),
    .rdata_o (rd_bits)
  );

  sre_rot u_rot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && slot.second),
    .slot_i      (slot),
    .x2_i        (in_data_i.element_value),
    .entry_i     (sre_pkg::entry_t'(rd_bits)),
    .ready_o     (rot_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/sre_checker.sv
// ----------------------------------------------------------------------------
// sre_checker
// Port-level checks for the streaming rotary embedding unit.
// ----------------------------------------------------------------------------
module sre_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input sre_pkg::out_req_t            out_data_o
);

  // a held output request stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // input backs up only when the output is full and held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind streaming_rotary_embedding_unit sre_checker u_sre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### bench/tb_streaming_rotary_embedding_unit.sv
// ----------------------------------------------------------------------------
// tb_streaming_rotary_embedding_unit
// Self-checking bench for the streaming rotary embedding unit. A short table of
// element pairs covers the value and coefficient extremes and the rounding
// corners. It is followed by random phases that reprogram the three registers
// over the APB port, extremes included, and stream whole or partial head
// vectors. A bit-accurate rotation model checks every output request. Both
// sides idle at random, and the receiver holds off for a long stretch twice.
// ----------------------------------------------------------------------------
module tb_streaming_rotary_embedding_unit;
  import sre_pkg::*;

  localparam int unsigned MaxPairs    = 64;
  localparam int unsigned ItemTarget  = 1400;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned PipeSettle  = 8;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned MaxReports  = 40;
  localparam longint      SatHi       = (longint'(1) << (DataW - 1)) - 1;
  localparam longint      SatLo       = -SatHi - 1;

  // one directed pair: first-half element with coefficients, then its partner
  typedef struct packed {
    logic signed [DataW-1:0] x1;
    logic signed [CoefW-1:0] c;
    logic signed [CoefW-1:0] s;
    logic signed [DataW-1:0] x2;
    logic                    fixed;
    logic signed [DataW-1:0] r1;
    logic signed [DataW-1:0] r2;
    logic                    sat;
  } pair_case_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_req_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_req_t            out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [RegAddrW-1:0] paddr;
  logic [RegDataW-1:0] pwdata;
  logic [RegDataW-1:0] prdata;
  logic                pready;

  // rotation model state
  in_req_t          pair_store [MaxPairs];
  bit               pair_written [MaxPairs];
  int unsigned      elem_cnt;
  int unsigned      head_cnt;
  int unsigned      pos_cnt;
  logic [HalfW-1:0] cfg_half      = HalfWidthRst;
  logic [HeadW-1:0] cfg_heads     = HeadCountRst;
  logic [PosW-1:0]  cfg_positions = PositionCountRst;

  out_req_t    rotation_q [$];
  out_req_t    want;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned pairs_seen;
  int unsigned sat_seen;
  int unsigned last_seen;
  int unsigned settings_used;
  int unsigned cycle_count;
  bit          tx_busy;
  bit          rx_busy;
  bit          hold_off_req;

  pair_case_t dir_cases [12] = '{
    '{16'sd0,      16'sd0,      16'sd0,      16'sd0,      1'b1, 16'sd0,     16'sd0,     1'b0},
    '{16'sd32767,  16'sd16384,  16'sd0,      16'sh8000,   1'b1, 16'sd32767, 16'sh8000,  1'b0},
    '{16'sd32767,  16'sd16384,  16'sd16384,  16'sd32767,  1'b1, 16'sd0,     16'sd32767, 1'b1},
    '{16'sh8000,   -16'sd16384, -16'sd16384, 16'sh8000,   1'b1, 16'sd0,     16'sd32767, 1'b1},
    '{16'sh8000,   -16'sd16384, 16'sd0,      16'sd0,      1'b1, 16'sd32767, 16'sd0,     1'b1},
    '{16'sd1,      16'sd8192,   16'sd0,      16'sd0,      1'b1, 16'sd1,     16'sd0,     1'b0},
    '{-16'sd1,     16'sd8192,   16'sd0,      16'sd0,      1'b1, 16'sd0,     16'sd0,     1'b0},
    '{16'sh8000,   16'sd16384,  -16'sd16384, 16'sd32767,  1'b0, 16'sd0,     16'sd0,     1'b0},
    '{16'sd32767,  16'sd32767,  16'sh8000,   16'sd32767,  1'b0, 16'sd0,     16'sd0,     1'b0},
    '{16'sh8000,   16'sh8000,   16'sh8000,   16'sh8000,   1'b0, 16'sd0,     16'sd0,     1'b0},
    '{16'sd12345,  16'sd11585,  16'sd11585,  -16'sd4321,  1'b0, 16'sd0,     16'sd0,     1'b0},
    '{16'sh5555,   16'sh2aaa,   -16'sd1,     16'shaaaa,   1'b0, 16'sd0,     16'sd0,     1'b0}
  };

  streaming_rotary_embedding_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               rotation_q.size());
      $display("tb_streaming_rotary_embedding_unit: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    if (error_count < MaxReports)
      $display("MISMATCH %s: got %0d, want %0d (pair %0d)", what, got, exp_val, pairs_seen);
    error_count++;
  endtask

  // register values of 0 act as 1, values above the limit act as the limit
  function automatic int unsigned active_count(input int unsigned raw, input int unsigned hi);
    if (raw == 0) return 1;
    return (raw > hi) ? hi : raw;
  endfunction

  // round half up at the Q2.14 point, then clip to the data width
  function automatic logic signed [DataW-1:0] round_sat(input longint acc, inout bit clip);
    longint q;
    q = (acc + (longint'(1) << (CoefFracBits - 1))) >>> CoefFracBits;
    if (q > SatHi) begin
      clip = 1'b1;
      q = SatHi;
    end else if (q < SatLo) begin
      clip = 1'b1;
      q = SatLo;
    end
    return q[DataW-1:0];
  endfunction

  // advances the stream position; returns 1 with the rotated pair for a
  // second-half element
  function automatic bit rotate_element(input in_req_t d, output out_req_t r);
    int unsigned h;
    int unsigned heads;
    int unsigned poss;
    int unsigned j;
    longint x1;
    longint c;
    longint s;
    longint x2;
    bit clip;
    h = active_count(cfg_half, MaxPairs);
    heads = active_count(cfg_heads, MaxHeads);
    poss = active_count(cfg_positions, MaxPositions);
    r = '0;
    clip = 1'b0;
    if (elem_cnt >= 2 * h) elem_cnt = 0;
    if (elem_cnt < h) begin
      pair_store[elem_cnt] = d;
      pair_written[elem_cnt] = 1'b1;
      elem_cnt++;
      return 1'b0;
    end
    j = elem_cnt - h;
    x1 = pair_store[j].element_value;
    c = pair_store[j].cos_value;
    s = pair_store[j].sin_value;
    x2 = d.element_value;
    r.rotated_first = round_sat(x1 * c - x2 * s, clip);
    r.rotated_second = round_sat(x2 * c + x1 * s, clip);
    r.pair_index = j[PairW-1:0];
    r.saturated = clip;
    r.last_of_run = (j == h - 1) && (head_cnt == heads - 1) && (pos_cnt == poss - 1);
    elem_cnt++;
    if (elem_cnt >= 2 * h) begin
      elem_cnt = 0;
      head_cnt++;
      if (head_cnt >= heads) begin
        head_cnt = 0;
        pos_cnt++;
        if (pos_cnt >= poss) pos_cnt = 0;
      end
    end
    return 1'b1;
  endfunction

  function automatic in_req_t random_element();
    in_req_t d;
    case ($urandom_range(0, 7))
      0: d.element_value = 16'sh7fff;
      1: d.element_value = 16'sh8000;
      default: d.element_value = DataW'($urandom());
    endcase
    if ($urandom_range(0, 7) == 0) begin
      // coefficients outside the unit range
      d.cos_value = CoefW'($urandom());
      d.sin_value = CoefW'($urandom());
    end else begin
      d.cos_value = CoefW'(int'($urandom_range(0, 32768)) - 16384);
      d.sin_value = CoefW'(int'($urandom_range(0, 32768)) - 16384);
    end
    return d;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic reg_access(input bit wr, input reg_idx_e idx, input logic [RegDataW-1:0] wdata,
                            output logic [RegDataW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_registers();
    logic [RegDataW-1:0] rd;
    logic [RegDataW-1:0] exp_val;
    for (int i = 0; i < 3; i++) begin
      reg_access(1'b0, reg_idx_e'(i), '0, rd);
      case (reg_idx_e'(i))
        REG_HALF_WIDTH:  exp_val = RegDataW'(cfg_half);
        REG_HEAD_COUNT:  exp_val = RegDataW'(cfg_heads);
        default:         exp_val = RegDataW'(cfg_positions);
      endcase
      if (rd !== exp_val) report_mismatch($sformatf("register %0d readback", i), rd, exp_val);
    end
  endtask

  task automatic program_setting(input logic [HalfW-1:0] half, input logic [HeadW-1:0] heads,
                                 input logic [PosW-1:0] positions);
    logic [RegDataW-1:0] rd;
    reg_access(1'b1, REG_HALF_WIDTH, RegDataW'(half), rd);
    cfg_half = half;
    reg_access(1'b1, REG_HEAD_COUNT, RegDataW'(heads), rd);
    cfg_heads = heads;
    reg_access(1'b1, REG_POSITION_COUNT, RegDataW'(positions), rd);
    cfg_positions = positions;
    settings_used++;
    check_registers();
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_element(input in_req_t d, input bit fixed, input out_req_t fixed_r);
    int unsigned gap;
    out_req_t r;
    gap = tx_busy ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (rotate_element(d, r)) rotation_q.push_back(fixed ? fixed_r : r);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_stream();
    in_valid_i <= 1'b0;
    while (rotation_q.size() != 0) @(posedge clk_i);
    // settle before the next setting; first-half elements produce no requests
    repeat (PipeSettle) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver: random stalls per request, plus long hold-offs on demand
  initial begin : receiver
    int unsigned stall_cycles;
    int unsigned taken;
    out_stall_i = 1'b0;
    taken = 0;
    @(negedge clk_i);
    forever begin
      if (taken % 32 == 0) rx_busy = ($urandom_range(0, 2) != 0);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      stall_cycles = rx_busy ? $urandom_range(0, 18) : 0;
      if (stall_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      taken++;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (rotation_q.size() == 0) begin
        report_mismatch("request with none expected, pair_index", out_data_o.pair_index, -1);
      end else begin
        want = rotation_q.pop_front();
        if (out_data_o.rotated_first !== want.rotated_first)
          report_mismatch("rotated_first", out_data_o.rotated_first, want.rotated_first);
        if (out_data_o.rotated_second !== want.rotated_second)
          report_mismatch("rotated_second", out_data_o.rotated_second, want.rotated_second);
        if (out_data_o.pair_index !== want.pair_index)
          report_mismatch("pair_index", out_data_o.pair_index, want.pair_index);
        if (out_data_o.saturated !== want.saturated)
          report_mismatch("saturated", out_data_o.saturated, want.saturated);
        if (out_data_o.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", out_data_o.last_of_run, want.last_of_run);
        if (want.saturated) sat_seen++;
        if (want.last_of_run) last_seen++;
      end
      pairs_seen++;
    end
  end

  initial begin : stimulus
    out_req_t fixed_r;
    in_req_t d;
    logic [HalfW-1:0] new_half;
    logic [HeadW-1:0] new_heads;
    logic [PosW-1:0] new_positions;
    int unsigned h;
    int unsigned lo;
    int unsigned hi;
    int unsigned n;
    int unsigned phase;
    bit ok;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_busy = 1'b0;
    hold_off_req = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    check_registers();

    // directed pairs, one pair per head vector, so every pair ends the run
    program_setting(7'd1, 7'd1, 13'd1);
    foreach (dir_cases[i]) begin
      tx_busy = (i % 3 == 2);
      fixed_r = '0;
      fixed_r.rotated_first = dir_cases[i].r1;
      fixed_r.rotated_second = dir_cases[i].r2;
      fixed_r.saturated = dir_cases[i].sat;
      fixed_r.last_of_run = 1'b1;
      d = '{element_value: dir_cases[i].x1, cos_value: dir_cases[i].c,
            sin_value: dir_cases[i].s};
      send_element(d, 1'b0, fixed_r);
      // partner coefficients are ignored by the block
      d = '{element_value: dir_cases[i].x2, cos_value: CoefW'($urandom()),
            sin_value: CoefW'($urandom())};
      send_element(d, dir_cases[i].fixed, fixed_r);
    end
    drain_stream();

    phase = 0;
    while (items_sent < ItemTarget) begin
      // a raised half width must not pair with a never-written store entry
      new_half = cfg_half;
      for (int t = 0; t < 8; t++) begin
        case ($urandom_range(0, 9))
          0: new_half = 7'd0;
          1: new_half = 7'd1;
          2: new_half = 7'd64;
          3: new_half = HalfW'($urandom_range(65, 127));
          4: new_half = HalfW'($urandom_range(17, 63));
          default: new_half = HalfW'($urandom_range(2, 16));
        endcase
        h = active_count(new_half, MaxPairs);
        ok = 1'b1;
        if (elem_cnt < 2 * h) begin
          lo = (elem_cnt < h) ? 0 : elem_cnt - h;
          hi = (elem_cnt < h) ? elem_cnt : h;
          for (int k = lo; k < hi; k++)
            if (!pair_written[k]) ok = 1'b0;
        end
        if (ok) break;
        new_half = cfg_half;
      end
      case ($urandom_range(0, 5))
        0: new_heads = 7'd0;
        1: new_heads = 7'd64;
        2: new_heads = HeadW'($urandom_range(65, 127));
        default: new_heads = HeadW'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 7))
        0: new_positions = 13'd0;
        1: new_positions = 13'd4096;
        2: new_positions = 13'd8191;
        3: new_positions = PosW'($urandom_range(4097, 8190));
        default: new_positions = PosW'($urandom_range(1, 4));
      endcase
      program_setting(new_half, new_heads, new_positions);

      h = active_count(cfg_half, MaxPairs);
      n = ((h > 16) ? $urandom_range(1, 2) : $urandom_range(1, 12)) * 2 * h;
      // a ragged tail leaves the next setting to start mid-vector
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 2 * h - 1);
      tx_busy = ($urandom_range(0, 2) != 0);
      if (phase == 2 || phase == 9) begin
        tx_busy = 1'b0;
        hold_off_req = 1'b1;
        if (n < 64) n += 64;
      end
      repeat (n) send_element(random_element(), 1'b0, '0);
      drain_stream();
      phase++;
    end

    $display("covered %0d elements and %0d rotated pairs over %0d register settings",
             items_sent, pairs_seen, settings_used);
    $display("%0d pairs clipped, %0d carried the end-of-run flag", sat_seen, last_seen);
    if (error_count == 0) begin
      $display("tb_streaming_rotary_embedding_unit: done, clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_streaming_rotary_embedding_unit: done, errors");
    end
    $finish;
  end

endmodule
